// ===== rtl/assert_macros.svh =====
// assertion macros for the rtl of the character reader
// no dependencies; taken in by include where checks are written
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every rising edge outside reset
`define MCR_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// expression must never be true at a rising edge outside reset
`define MCR_ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");

`else

`define MCR_ASSERT(label, clk, rst, prop)
`define MCR_ASSERT_NEVER(label, clk, rst, expr)

`endif

`endif

// ===== rtl/mcr_pkg.sv =====
// shared types and constants of the multi-charset character reader
// no dependencies; imported by the decoder and the top level
package mcr_pkg;

   typedef enum logic [1:0] {
      MODE_EUCJP = 2'd0,
      MODE_SJIS  = 2'd1,
      MODE_UTF8  = 2'd2,
      MODE_UTF16 = 2'd3
   } mode_type;

   localparam logic [7:0]  EUC_SS3_LEAD  = 8'h8F;
   localparam logic [5:0]  SURR_HI_TAG   = 6'b110110;
   localparam logic [5:0]  SURR_LO_TAG   = 6'b110111;
   localparam logic [23:0] SUPP_BASE     = 24'h010000;
   localparam logic [2:0]  UNITS_INVALID = 3'd0;
   localparam logic [2:0]  UNITS_MAX     = 3'd4;

   typedef struct packed {
      logic [15:0] unit0;
      logic [15:0] unit1;
      logic [15:0] unit2;
      logic [15:0] unit3;
   } req_type;

   typedef struct packed {
      logic [23:0] char_code;
      logic [2:0]  units_used;
   } rsp_type;

endpackage

// ===== rtl/multi_charset_char_reader_unit.sv =====
// top level of the multi-charset character reader
// depends on mcr_pkg, mcr_decoder and assert_macros.svh
//
// decodes the one character at the head of a four unit window in the
// encoding chosen by csr_wr_data (0 euc-jp, 1 shift_jis, 2 utf-8, 3 utf-16).
// a transaction is taken whenever start is high and busy is low; busy is
// high only while reset is asserted, so one window per clock is sustained.
// each window gives exactly one result: it waits in the input register,
// then passes through the decoder into the result register. rsp_strobe
// marks the result for a single cycle and cannot be held off, so the
// receiver must take it then. units_used of zero flags an invalid
// sequence, with char_code forced to zero. in byte modes only the low 8
// bits of each unit are looked at. write the mode only while no
// transaction is in flight.
`include "assert_macros.svh"

module multi_charset_char_reader_unit
   import mcr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   // request transaction
   input  logic       start,
   output logic       busy,
   input  req_type    req_data,
   // result transaction
   output logic       rsp_strobe,
   output rsp_type    rsp_data,
   // mode register
   input  logic       csr_wr_en,
   input  logic [1:0] csr_wr_data
);

   // mode register
   mode_type mode_ff, mode_in;

   // input stage: captured window and its valid flag
   logic    req_valid_ff, req_valid_in;
   req_type req_data_ff;

   // result stage
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   logic accept;

   // no stall source inside, only reset holds requests off
   assign busy   = reset;
   assign accept = start && !busy;

   assign mode_in      = csr_wr_en ? mode_type'(csr_wr_data) : mode_ff;
   assign req_valid_in = accept;
   assign rsp_valid_in = req_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_EUCJP;
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (accept) begin
         req_data_ff <= req_data;
      end
      if (req_valid_ff) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // single pass decode between the two register stages
   mcr_decoder u_decoder (
      .mode   (mode_ff),
      .window (req_data_ff),
      .result (rsp_data_in)
   );

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   // every taken transaction yields a result through the input and result registers
   `MCR_ASSERT(a_accept_to_result, clock, reset, accept |-> ##2 rsp_strobe)
   // no result without a transaction taken earlier
   `MCR_ASSERT(a_result_has_source, clock, reset, rsp_strobe |-> $past(accept, 2))
   // an invalid result carries a zero code
   `MCR_ASSERT_NEVER(a_invalid_code_zero, clock, reset,
      rsp_strobe && rsp_data.units_used == UNITS_INVALID && rsp_data.char_code != 24'h0)
   // length never exceeds the window
   `MCR_ASSERT_NEVER(a_length_in_window, clock, reset,
      rsp_strobe && rsp_data.units_used > UNITS_MAX)

endmodule

// ===== rtl/mcr_decoder.sv =====
// combinational decode of the character at the head of a four unit window
// depends on mcr_pkg for the window, result and mode types
module mcr_decoder
   import mcr_pkg::*;
(
   input  mode_type mode,
   input  req_type  window,
   output rsp_type  result
);

   logic [7:0]  b0, b1, b2, b3;
   logic        t1, t2, t3;
   logic        hi0, lo0, lo1, zero1;
   logic [23:0] code;
   logic [2:0]  used;

   assign b0 = window.unit0[7:0];
   assign b1 = window.unit1[7:0];
   assign b2 = window.unit2[7:0];
   assign b3 = window.unit3[7:0];

   // utf-8 continuation bytes are 10xxxxxx
   assign t1 = (b1[7:6] == 2'b10);
   assign t2 = (b2[7:6] == 2'b10);
   assign t3 = (b3[7:6] == 2'b10);

   assign hi0   = (window.unit0[15:10] == SURR_HI_TAG);
   assign lo0   = (window.unit0[15:10] == SURR_LO_TAG);
   assign lo1   = (window.unit1[15:10] == SURR_LO_TAG);
   assign zero1 = (window.unit1 == 16'h0000);

   always_comb begin
      code = 24'h000000;
      used = UNITS_INVALID;
      unique case (mode)
         MODE_EUCJP: begin
            if (b0 <= 8'h7F) begin
               code = {16'h0000, b0};
               used = 3'd1;
            end else if (b0 != EUC_SS3_LEAD) begin
               code = {8'h00, b0, b1};
               used = 3'd2;
            end else begin
               code = {b0, b1, b2};
               used = 3'd3;
            end
         end
         MODE_SJIS: begin
            if (b0 <= 8'h7F || (b0 >= 8'hA1 && b0 <= 8'hDF)) begin
               code = {16'h0000, b0};
               used = 3'd1;
            end else if ((b0 >= 8'h81 && b0 <= 8'h9F) || (b0 >= 8'hE0 && b0 <= 8'hFC)) begin
               code = {8'h00, b0, b1};
               used = 3'd2;
            end
         end
         MODE_UTF8: begin
            if (b0 < 8'h80) begin
               code = {16'h0000, b0};
               used = 3'd1;
            end else if (b0 >= 8'hC2 && b0 < 8'hE0) begin
               if (t1) begin
                  code = {13'h0000, b0[4:0], b1[5:0]};
                  used = 3'd2;
               end
            end else if (b0 >= 8'hE0 && b0 < 8'hF0) begin
               // overlong when the lead nibble and b1 bit 5 are all zero
               if (t1 && t2 && !(b0[3:0] == 4'h0 && !b1[5])) begin
                  code = {8'h00, b0[3:0], b1[5:0], b2[5:0]};
                  used = 3'd3;
               end
            end else if (b0 >= 8'hF0 && b0 < 8'hF8) begin
               if (t1 && t2 && t3 && !(b0[2:0] == 3'h0 && b1[5:4] == 2'b00)) begin
                  code = {3'b000, b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
                  used = UNITS_MAX;
               end
            end
         end
         MODE_UTF16: begin
            if (hi0 && lo1) begin
               code = SUPP_BASE + {4'h0, window.unit0[9:0], window.unit1[9:0]};
               used = 3'd2;
            end else if ((hi0 || lo0) && zero1) begin
               // lone surrogate followed by a zero unit passes through
               code = {8'h00, window.unit0};
               used = 3'd2;
            end else if (!hi0 && !lo0) begin
               code = {8'h00, window.unit0};
               used = 3'd1;
            end
         end
         default: begin
            code = 24'h000000;
            used = UNITS_INVALID;
         end
      endcase
   end

   assign result.char_code  = (used == UNITS_INVALID) ? 24'h000000 : code;
   assign result.units_used = used;

endmodule
